// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

  localparam int unsigned FRAME_LEN_CAP = 65536;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [7:0]  HEAD_RST    = 8'hFF;
  localparam logic [7:0]  TAIL_RST    = 8'hFE;
  localparam logic [31:0] VERIFY_RST  = 32'h4142_4344;
  localparam logic [16:0] MAX_LEN_RST = 17'd65536;

  // positions of the fixed header fields
  localparam logic [15:0] POS_LAST_VERIFY = 16'd4;
  localparam logic [15:0] POS_SEQ         = 16'd5;
  localparam logic [15:0] POS_CMD         = 16'd6;
  localparam logic [15:0] POS_LEN0        = 16'd7;
  localparam logic [15:0] POS_LEN1        = 16'd8;
  localparam logic [15:0] POS_LEN2        = 16'd9;
  localparam logic [15:0] POS_LEN3        = 16'd10;
  localparam logic [15:0] POS_PAYLOAD     = 16'd11;
  localparam logic [16:0] FRAME_OVERHEAD  = 17'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD    = 8'd0,
    CFG_TAIL    = 8'd1,
    CFG_VERIFY  = 8'd2,
    CFG_MAX_LEN = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_VERIFY = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    EV_OUT     = 3'd0,
    EV_IN      = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BADTAIL = 3'd3,
    EV_LONG    = 3'd4
  } event_e;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [31:0] verify_word;
    logic [16:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] frame_pos;
    event_e      event_res;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_cmd;
    logic [15:0] payload_len;
  } res_t;

endpackage

// ----- rtl/sfd_if.sv -----
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] frame_pos;
  logic [2:0]  event_res;
  logic [7:0]  frame_seq;
  logic [7:0]  frame_cmd;
  logic [15:0] payload_len;

  modport source (output valid, output out_byte, output frame_pos, output event_res,
                  output frame_seq, output frame_cmd, output payload_len, input ready);
  modport sink   (input valid, input out_byte, input frame_pos, input event_res,
                  input frame_seq, input frame_cmd, input payload_len, output ready);
endinterface

interface sfd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]    index;
  logic [sfd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sync_frame_deframer.sv -----
// Frame finder for a received byte stream.
// in_ch   : one received byte per beat (valid/ready).
// out_ch  : one result per input byte, in order: the byte, its offset in the
//           frame, seq, cmd and payload length as far as known, and an event
//           (outside, in frame, good end, bad tail, too long).
// cfg_ch  : register writes (index, data), taken in every cycle; write only
//           while no byte is in flight.
// Path    : an accepted byte is held in the input register, and its result is
//           written to the result register when the byte advances.
// Rate    : one byte per cycle sustained while out_ch is ready; the frame state
//           is updated once per byte as it moves from input to result register.
// Stall   : when out_ch is not ready the result holds, the input register
//           keeps one more byte, then in_ch ready drops until the result goes.
// Reset   : rst_ni clears the frame state to hunting, empties both registers
//           and restores the register defaults (head 0xFF, tail 0xFE,
//           verify "ABCD", 65536-byte frame limit).
module sync_frame_deframer #(
  parameter int unsigned MAX_FRAME_LEN = sfd_pkg::FRAME_LEN_CAP
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch,
  sfd_cfg_if.sink   cfg_ch
);

  sfd_pkg::cfg_t cfg;
  sfd_pkg::res_t res_d, res_q;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       adv;

  assign adv          = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || adv;

  sfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_ch.valid),
    .wr_ready_o (cfg_ch.ready),
    .wr_index_i (cfg_ch.index),
    .wr_data_i  (cfg_ch.data),
    .cfg_o      (cfg)
  );

  sfd_core #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (byte_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_q <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.out_byte    = res_q.out_byte;
  assign out_ch.frame_pos   = res_q.frame_pos;
  assign out_ch.event_res   = res_q.event_res;
  assign out_ch.frame_seq   = res_q.frame_seq;
  assign out_ch.frame_cmd   = res_q.frame_cmd;
  assign out_ch.payload_len = res_q.payload_len;

  a_outside_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.event_res == sfd_pkg::EV_OUT |->
      res_q.frame_pos == 16'd0 && res_q.payload_len == 16'd0 &&
      res_q.frame_seq == 8'd0 && res_q.frame_cmd == 8'd0)
    else $error("outside-frame result carries frame fields");

  a_good_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.event_res == sfd_pkg::EV_GOOD |->
      res_q.frame_pos == res_q.payload_len + sfd_pkg::POS_PAYLOAD)
    else $error("good end not at the tail position");

  a_too_long_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.event_res == sfd_pkg::EV_LONG |->
      res_q.frame_pos == sfd_pkg::POS_LEN3 && res_q.payload_len == 16'd0)
    else $error("too-long result away from the last length byte");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(byte_q))
    else $error("held input byte lost or changed");

endmodule

// ----- rtl/sfd_cfg.sv -----
module sfd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_valid_i,
  output logic                           wr_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] wr_data_i,
  output sfd_pkg::cfg_t                  cfg_o
);

  sfd_pkg::cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte       <= sfd_pkg::HEAD_RST;
      cfg_q.tail_byte       <= sfd_pkg::TAIL_RST;
      cfg_q.verify_word     <= sfd_pkg::VERIFY_RST;
      cfg_q.max_frame_bytes <= sfd_pkg::MAX_LEN_RST;
    end else if (wr_valid_i) begin
      // unknown indexes drop the beat
      unique case (wr_index_i)
        sfd_pkg::CFG_HEAD:    cfg_q.head_byte       <= wr_data_i[7:0];
        sfd_pkg::CFG_TAIL:    cfg_q.tail_byte       <= wr_data_i[7:0];
        sfd_pkg::CFG_VERIFY:  cfg_q.verify_word     <= wr_data_i[31:0];
        sfd_pkg::CFG_MAX_LEN: cfg_q.max_frame_bytes <= wr_data_i[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/sfd_core.sv -----
module sfd_core #(
  parameter int unsigned MAX_FRAME_LEN = sfd_pkg::FRAME_LEN_CAP
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  input  sfd_pkg::cfg_t cfg_i,
  output sfd_pkg::res_t res_o
);

  localparam int unsigned LIMIT_CAP = (MAX_FRAME_LEN < sfd_pkg::FRAME_LEN_CAP) ?
                                      MAX_FRAME_LEN : sfd_pkg::FRAME_LEN_CAP;
  localparam logic [16:0] CAP = 17'(LIMIT_CAP);

  sfd_pkg::phase_e phase_q, phase_d;
  logic [15:0]     pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  logic            len_hi_q, len_hi_d;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      cmd_q, cmd_d;

  logic [7:0]  expect_byte;
  logic [16:0] limit;
  logic        too_long;
  logic        at_tail;

  always_comb begin
    unique case (pos_q[1:0])
      2'd1:    expect_byte = cfg_i.verify_word[31:24];
      2'd2:    expect_byte = cfg_i.verify_word[23:16];
      2'd3:    expect_byte = cfg_i.verify_word[15:8];
      default: expect_byte = cfg_i.verify_word[7:0];
    endcase
  end

  assign limit    = (cfg_i.max_frame_bytes < CAP) ? cfg_i.max_frame_bytes : CAP;
  // upper length bytes nonzero always exceed any limit
  assign too_long = len_hi_q || (byte_i != 8'd0) ||
                    (({1'b0, len_q} + sfd_pkg::FRAME_OVERHEAD) > limit);
  assign at_tail  = {1'b0, pos_q} >= ({1'b0, len_q} + {1'b0, sfd_pkg::POS_PAYLOAD});

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    len_hi_d = len_hi_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;

    res_o.out_byte    = byte_i;
    res_o.frame_pos   = '0;
    res_o.event_res   = sfd_pkg::EV_OUT;
    res_o.frame_seq   = '0;
    res_o.frame_cmd   = '0;
    res_o.payload_len = '0;

    unique case (phase_q)
      sfd_pkg::PH_HUNT: begin
        if (byte_i == cfg_i.head_byte) begin
          phase_d         = sfd_pkg::PH_VERIFY;
          pos_d           = 16'd1;
          res_o.event_res = sfd_pkg::EV_IN;
        end
      end
      sfd_pkg::PH_VERIFY: begin
        if (byte_i == expect_byte) begin
          res_o.frame_pos = pos_q;
          res_o.event_res = sfd_pkg::EV_IN;
          pos_d           = pos_q + 16'd1;
          if (pos_q == sfd_pkg::POS_LAST_VERIFY) begin
            phase_d = sfd_pkg::PH_HEADER;
          end
        end else if (byte_i == cfg_i.head_byte) begin
          // restart on a fresh head byte
          pos_d           = 16'd1;
          res_o.event_res = sfd_pkg::EV_IN;
        end else begin
          phase_d = sfd_pkg::PH_HUNT;
          pos_d   = '0;
        end
      end
      sfd_pkg::PH_HEADER: begin
        res_o.frame_pos = pos_q;
        res_o.event_res = sfd_pkg::EV_IN;
        if (pos_q == sfd_pkg::POS_SEQ)  seq_d = byte_i;
        if (pos_q == sfd_pkg::POS_CMD)  cmd_d = byte_i;
        if (pos_q == sfd_pkg::POS_LEN0) len_d[7:0]  = byte_i;
        if (pos_q == sfd_pkg::POS_LEN1) len_d[15:8] = byte_i;
        if (pos_q == sfd_pkg::POS_LEN2) len_hi_d    = byte_i != 8'd0;
        res_o.frame_seq = seq_d;
        res_o.frame_cmd = cmd_d;
        if (pos_q == sfd_pkg::POS_LEN3) begin
          if (too_long) begin
            res_o.event_res = sfd_pkg::EV_LONG;
            phase_d  = sfd_pkg::PH_HUNT;
            pos_d    = '0;
            len_d    = '0;
            len_hi_d = 1'b0;
            seq_d    = '0;
            cmd_d    = '0;
          end else begin
            res_o.payload_len = len_q;
            phase_d           = sfd_pkg::PH_BODY;
            pos_d             = sfd_pkg::POS_PAYLOAD;
          end
        end else begin
          pos_d = pos_q + 16'd1;
        end
      end
      sfd_pkg::PH_BODY: begin
        res_o.frame_pos   = pos_q;
        res_o.frame_seq   = seq_q;
        res_o.frame_cmd   = cmd_q;
        res_o.payload_len = len_q;
        if (at_tail) begin
          res_o.event_res = (byte_i == cfg_i.tail_byte) ? sfd_pkg::EV_GOOD :
                                                          sfd_pkg::EV_BADTAIL;
          phase_d  = sfd_pkg::PH_HUNT;
          pos_d    = '0;
          len_d    = '0;
          len_hi_d = 1'b0;
          seq_d    = '0;
          cmd_d    = '0;
        end else begin
          res_o.event_res = sfd_pkg::EV_IN;
          pos_d           = pos_q + 16'd1;
        end
      end
      default: begin
        phase_d  = sfd_pkg::PH_HUNT;
        pos_d    = '0;
        len_d    = '0;
        len_hi_d = 1'b0;
        seq_d    = '0;
        cmd_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfd_pkg::PH_HUNT;
      pos_q    <= '0;
      len_q    <= '0;
      len_hi_q <= 1'b0;
      seq_q    <= '0;
      cmd_q    <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      len_hi_q <= len_hi_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned POS_SPACE   = 65536;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned PHASE_ITEMS = 270;
  localparam logic [7:0]  CFG_SPARE_IDX = 8'd200;

  class deframe_scoreboard;
    logic [7:0]  head_q;
    logic [7:0]  tail_q;
    logic [31:0] verify_q;
    logic [16:0] max_q;

    phase_e      ph;
    logic [15:0] bpos;
    logic [31:0] len_acc;
    logic [7:0]  seq_acc;
    logic [7:0]  cmd_acc;

    res_t        frame_results_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_good;
    int unsigned n_bad;
    int unsigned n_long;

    function new();
      head_q   = HEAD_RST;
      tail_q   = TAIL_RST;
      verify_q = VERIFY_RST;
      max_q    = MAX_LEN_RST;
      errors   = 0;
      checked  = 0;
      n_good   = 0;
      n_bad    = 0;
      n_long   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph      = PH_HUNT;
      bpos    = '0;
      len_acc = '0;
      seq_acc = '0;
      cmd_acc = '0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        CFG_HEAD:    head_q   = val[7:0];
        CFG_TAIL:    tail_q   = val[7:0];
        CFG_VERIFY:  verify_q = val;
        CFG_MAX_LEN: max_q    = val[16:0];
        default: ;
      endcase
    endfunction

    function int unsigned limit();
      int unsigned lim;
      lim = max_q;
      if (lim > FRAME_LEN_CAP) lim = FRAME_LEN_CAP;
      if (lim > POS_SPACE) lim = POS_SPACE;
      return lim;
    endfunction

    // one byte through the frame finder
    function res_t deframe(logic [7:0] b);
      res_t        r;
      logic [7:0]  want_v;
      logic [63:0] total;
      r = '0;
      r.out_byte  = b;
      r.event_res = EV_OUT;
      case (ph)
        PH_HUNT: begin
          if (b == head_q) begin
            ph          = PH_VERIFY;
            bpos        = 16'd1;
            r.event_res = EV_IN;
          end
        end
        PH_VERIFY: begin
          want_v = verify_q[8*(4 - int'(bpos)) +: 8];
          if (b == want_v) begin
            r.frame_pos = bpos;
            r.event_res = EV_IN;
            bpos++;
            if (bpos > POS_LAST_VERIFY) ph = PH_HEADER;
          end else if (b == head_q) begin
            // restart on a fresh head byte
            clear_frame();
            ph          = PH_VERIFY;
            bpos        = 16'd1;
            r.event_res = EV_IN;
          end else begin
            clear_frame();
          end
        end
        PH_HEADER: begin
          r.frame_pos = bpos;
          r.event_res = EV_IN;
          if (bpos == POS_SEQ) seq_acc = b;
          else if (bpos == POS_CMD) cmd_acc = b;
          else if (bpos >= POS_LEN0 && bpos <= POS_LEN3)
            len_acc |= 32'(b) << (8 * (bpos - POS_LEN0));
          r.frame_seq = seq_acc;
          r.frame_cmd = cmd_acc;
          if (bpos >= POS_LEN3) begin
            total = 64'(len_acc) + 64'(FRAME_OVERHEAD);
            if (total > 64'(limit())) begin
              r.event_res = EV_LONG;
              clear_frame();
            end else begin
              r.payload_len = len_acc[15:0];
              ph            = PH_BODY;
              bpos          = POS_PAYLOAD;
            end
          end else begin
            bpos++;
          end
        end
        default: begin
          r.frame_pos   = bpos;
          r.frame_seq   = seq_acc;
          r.frame_cmd   = cmd_acc;
          r.payload_len = len_acc[15:0];
          if (64'(bpos) >= 64'(len_acc) + 64'(POS_PAYLOAD)) begin
            r.event_res = (b == tail_q) ? EV_GOOD : EV_BADTAIL;
            clear_frame();
          end else begin
            r.event_res = EV_IN;
            bpos++;
          end
        end
      endcase
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      res_t r;
      r = deframe(b);
      case (r.event_res)
        EV_GOOD:    n_good++;
        EV_BADTAIL: n_bad++;
        EV_LONG:    n_long++;
        default: ;
      endcase
      frame_results_q.push_back(r);
    endfunction

    function int unsigned pending();
      return frame_results_q.size();
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (frame_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected, actual byte %0h event %0d",
                   $time, got.out_byte, got.event_res);
        return;
      end
      want = frame_results_q.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte) mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.frame_pos !== want.frame_pos) mismatch("frame_pos", want.frame_pos, got.frame_pos);
      if (got.event_res !== want.event_res) mismatch("event_res", want.event_res, got.event_res);
      if (got.frame_seq !== want.frame_seq) mismatch("frame_seq", want.frame_seq, got.frame_seq);
      if (got.frame_cmd !== want.frame_cmd) mismatch("frame_cmd", want.frame_cmd, got.frame_cmd);
      if (got.payload_len !== want.payload_len)
        mismatch("payload_len", want.payload_len, got.payload_len);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();
  sfd_cfg_if cfg_ch ();

  sync_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframe_scoreboard sb;
  logic [7:0]  tx_q[$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned sent_cnt;
  int unsigned settings_cnt;
  int unsigned cycle_cnt;

  always #10 clk_i = ~clk_i;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("simulation failed");
    $finish;
  end

  // result side: check the beat, then pick ready for the next cycle
  initial begin
    res_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.out_byte    = out_ch.out_byte;
        got.frame_pos   = out_ch.frame_pos;
        got.event_res   = event_e'(out_ch.event_res);
        got.frame_seq   = out_ch.frame_seq;
        got.frame_cmd   = out_ch.frame_cmd;
        got.payload_len = out_ch.payload_len;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    sb.note_byte(b);
    sent_cnt++;
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // hold off until every result is in and the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (cfg_ch.ready !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                            input logic [31:0] verify, input logic [16:0] maxb);
    drain();
    write_reg(CFG_HEAD, 32'(head));
    write_reg(CFG_TAIL, 32'(tail));
    write_reg(CFG_VERIFY, verify);
    write_reg(CFG_MAX_LEN, 32'(maxb));
    // an index past the register list must change nothing
    write_reg(CFG_SPARE_IDX, $urandom);
    cfg_ch.valid <= 1'b0;
    settings_cnt++;
  endtask

  function automatic void push_header(logic [31:0] len_field);
    tx_q.push_back(sb.head_q);
    tx_q.push_back(sb.verify_q[31:24]);
    tx_q.push_back(sb.verify_q[23:16]);
    tx_q.push_back(sb.verify_q[15:8]);
    tx_q.push_back(sb.verify_q[7:0]);
    tx_q.push_back(8'($urandom));
    tx_q.push_back(8'($urandom));
    tx_q.push_back(len_field[7:0]);
    tx_q.push_back(len_field[15:8]);
    tx_q.push_back(len_field[23:16]);
    tx_q.push_back(len_field[31:24]);
  endfunction

  function automatic void push_body(int unsigned len, bit good_tail);
    for (int unsigned i = 0; i < len; i++) tx_q.push_back(8'($urandom));
    if (good_tail) tx_q.push_back(sb.tail_q);
    else tx_q.push_back(sb.tail_q ^ 8'($urandom_range(255, 1)));
  endfunction

  function automatic int unsigned pick_len(int room);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(16);
    else len = $urandom_range(300);
    if (len > room) len = room;
    return len;
  endfunction

  function automatic void queue_random_burst();
    int          room;
    int unsigned k;
    int unsigned j;
    int unsigned n;
    logic [7:0]  want_v;
    logic [31:0] len_field;
    room = int'(sb.limit()) - int'(FRAME_OVERHEAD);
    k = $urandom_range(99);
    if (k < 55) begin
      if (room < 0) begin
        push_header($urandom);
      end else begin
        n = pick_len(room);
        push_header(n);
        push_body(n, k < 45);
      end
    end else if (k < 65) begin
      // too long: just past the limit, or wildly so
      j = $urandom_range(3);
      if (room < 0) len_field = $urandom;
      else if (j == 0) len_field = room + 1;
      else if (j == 1) len_field = room + 1 + $urandom_range(20);
      else if (j == 2) len_field = 32'hFFFF_FFFF;
      else len_field = $urandom | 32'h0100_0000;
      push_header(len_field);
    end else if (k < 72 && room >= 0 && room <= 400) begin
      // exactly at the limit
      push_header(room);
      push_body(room, 1'b1);
    end else if (k < 82) begin
      // verify broken after j good bytes
      j = $urandom_range(3);
      tx_q.push_back(sb.head_q);
      for (int unsigned i = 0; i < j; i++) tx_q.push_back(sb.verify_q[8*(3-i) +: 8]);
      want_v = sb.verify_q[8*(3-j) +: 8];
      if (sb.head_q != want_v && $urandom_range(2) == 0) tx_q.push_back(sb.head_q);
      else tx_q.push_back(want_v ^ 8'($urandom_range(255, 1)));
    end else begin
      n = $urandom_range(6, 1);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(4) == 0) tx_q.push_back(sb.head_q);
        else tx_q.push_back(8'($urandom));
      end
    end
  endfunction

  task automatic random_phase(input int unsigned target);
    int unsigned start;
    start = sent_cnt;
    while (sent_cnt - start < target) begin
      queue_random_burst();
      flush_tx();
    end
  endtask

  task automatic directed_bytes();
    logic [7:0] seqv [28];
    seqv = '{8'h00, HEAD_RST, VERIFY_RST[31:24], 8'h00,
             HEAD_RST, HEAD_RST, VERIFY_RST[31:24], VERIFY_RST[23:16],
             VERIFY_RST[15:8], VERIFY_RST[7:0], 8'hFF, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00, TAIL_RST,
             HEAD_RST, VERIFY_RST[31:24], VERIFY_RST[23:16],
             VERIFY_RST[15:8], VERIFY_RST[7:0], 8'h5A, 8'hA5,
             8'hFF, 8'hFF, 8'hFF, 8'hFF};
    foreach (seqv[i]) tx_q.push_back(seqv[i]);
    flush_tx();
  endtask

  initial begin
    sb = new();
    sent_cnt     = 0;
    settings_cnt = 1;
    src_idle_pct = 20;
    snk_idle_pct = 58;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: noise, broken verify, restart, empty frame, oversize
    directed_bytes();
    random_phase(PHASE_ITEMS);

    // verify bytes equal to the head byte, smallest legal frame
    set_config(8'h00, 8'hFF, 32'h0000_0000, 17'd12);
    random_phase(PHASE_ITEMS);

    src_idle_pct = 58;
    snk_idle_pct = 20;
    // limit below the overhead drops everything
    set_config(8'hFF, 8'hFF, 32'hFFFF_FFFF, 17'd5);
    random_phase(PHASE_ITEMS);

    set_config(8'($urandom), 8'($urandom), $urandom, 17'h1FFFF);
    random_phase(PHASE_ITEMS);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(8'($urandom), 8'($urandom), $urandom, 17'($urandom_range(400, 12)));
    random_phase(PHASE_ITEMS);

    // one byte past the largest frame the position space allows
    set_config(8'($urandom), 8'($urandom), $urandom, MAX_LEN_RST);
    push_header(32'(POS_SPACE) - 32'(FRAME_OVERHEAD) + 32'd1);
    flush_tx();
    random_phase(PHASE_ITEMS);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d bytes checked over %0d register settings", sb.checked, settings_cnt);
    $display("frames: %0d good, %0d bad tail, %0d too long; %0d mismatches",
             sb.n_good, sb.n_bad, sb.n_long, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/sfd_cfg.sv
rtl/sfd_core.sv
rtl/sync_frame_deframer.sv
bench/tb.sv
